>>> sv/pc_pkg.sv
// ---------------------------------------------------------------------------
// pc_pkg
// widths, types and constants shared by the pearson correlation block
// ---------------------------------------------------------------------------
package pc_pkg;

    localparam int MAX_SAMPLES = 4096;
    localparam int SAMPLE_BITS = 16;

    localparam int IN_W   = 16;
    localparam int RHO_W  = 16;
    localparam int FRAC_W = RHO_W - 1;
    localparam int K_W    = $clog2(FRAC_W);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = SAMPLE_BITS + CNT_W;
    localparam int SQ_W  = 2 * SAMPLE_BITS + CNT_W - 1;
    localparam int SPR_W = CNT_W + SQ_W;
    localparam int NUM_W = SPR_W + 1;
    localparam int NSH   = 2 * (FRAC_W + 1);
    localparam int W     = 2 * NUM_W + NSH + 2;

    localparam logic [RHO_W-1:0] RHO_MAX = RHO_W'((1 << (RHO_W - 1)) - 1);

    typedef struct packed {
        logic signed [SUM_W-1:0] sx;
        logic signed [SUM_W-1:0] sy;
        logic        [SQ_W-1:0]  sxx;
        logic        [SQ_W-1:0]  syy;
        logic signed [SQ_W-1:0]  sxy;
        logic        [CNT_W-1:0] cnt;
    } t_sums;

endpackage

>>> sv/pc_if.sv
// ---------------------------------------------------------------------------
// pc_in_if / pc_out_if
// valid/ready channels for sample pairs and correlation results
// ---------------------------------------------------------------------------
interface pc_in_if;
    logic                          valid;
    logic                          ready;
    logic signed [pc_pkg::IN_W-1:0] sample_x;
    logic signed [pc_pkg::IN_W-1:0] sample_y;
    logic                          last_sample;

    modport source (output valid, output sample_x, output sample_y, output last_sample,
                    input ready);
    modport sink (input valid, input sample_x, input sample_y, input last_sample,
                  output ready);
endinterface

interface pc_out_if;
    logic                           valid;
    logic                           ready;
    logic signed [pc_pkg::RHO_W-1:0] rho;
    logic                           undefined;

    modport source (output valid, output rho, output undefined, input ready);
    modport sink (input valid, input rho, input undefined, output ready);
endinterface

>>> sv/pearson_correlation.sv
// ---------------------------------------------------------------------------
// pearson_correlation
// streaming pearson coefficient in signed Q1.15 over columns of sample pairs
//
//   channel  dir  payload                            request
//   i_in     in   sample_x, sample_y, last_sample    one sample pair
//   o_out    out  rho, undefined                     one coefficient per column
//
// pairs are taken one per cycle; a pair marked last starts the evaluation
// evaluation runs on one shared 150-bit adder: shift-add products at one
// multiplier bit per cycle, then a 15-step bit search through S_T1, S_T2,
// S_CMP and, for a set bit, S_UPG; an undefined column skips the search;
// i_in is held off during evaluation and reopens once the result sits in
// the output register; synchronous active-low reset clears sums and control
// ---------------------------------------------------------------------------
module pearson_correlation (
    input  logic     i_clk,
    input  logic     i_rst_n,
    pc_in_if.sink    i_in,
    pc_out_if.source o_out
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_LOAD = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_POST = 4'd3;
    localparam logic [3:0] S_SWAP = 4'd4;
    localparam logic [3:0] S_CHK  = 4'd5;
    localparam logic [3:0] S_T1   = 4'd6;
    localparam logic [3:0] S_T2   = 4'd7;
    localparam logic [3:0] S_CMP  = 4'd8;
    localparam logic [3:0] S_UPG  = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    localparam logic [2:0] OP_NXX = 3'd0;
    localparam logic [2:0] OP_SXX = 3'd1;
    localparam logic [2:0] OP_NYY = 3'd2;
    localparam logic [2:0] OP_SYY = 3'd3;
    localparam logic [2:0] OP_NXY = 3'd4;
    localparam logic [2:0] OP_SXY = 3'd5;
    localparam logic [2:0] OP_NN  = 3'd6;
    localparam logic [2:0] OP_AB  = 3'd7;

    function automatic logic signed [pc_pkg::RHO_W-1:0] f_rho(
        input logic [pc_pkg::RHO_W-1:0] q,
        input logic                     neg
    );
        logic [pc_pkg::RHO_W-1:0] v;
        if (neg) begin
            v = pc_pkg::RHO_W'(0) - q;
        end else if (q[pc_pkg::RHO_W-1]) begin
            v = pc_pkg::RHO_MAX;
        end else begin
            v = q;
        end
        return $signed(v);
    endfunction

    pc_pkg::t_sums w_sums;
    logic          w_last_pend;
    logic          w_clear;
    logic          w_take;

    logic [3:0]                 r_state, n_state;
    logic [2:0]                 r_op, n_op;
    logic [pc_pkg::W-1:0]       r_acc, n_acc;
    logic [pc_pkg::W-1:0]       r_mcand, n_mcand;
    logic [pc_pkg::NUM_W-1:0]   r_mplier, n_mplier;
    logic [pc_pkg::W-1:0]       r_tmp, n_tmp;
    logic [pc_pkg::SPR_W-1:0]   r_pa, n_pa;
    logic [pc_pkg::SPR_W-1:0]   r_pb, n_pb;
    logic [pc_pkg::NUM_W-1:0]   r_num, n_num;
    logic                       r_neg, n_neg;
    logic [pc_pkg::W-1:0]       r_n, n_n;
    logic [pc_pkg::W-1:0]       r_e, n_e;
    logic [pc_pkg::W-1:0]       r_g, n_g;
    logic [pc_pkg::W-1:0]       r_dk, n_dk;
    logic [pc_pkg::FRAC_W-1:0]  r_u, n_u;
    logic [pc_pkg::K_W-1:0]     r_k, n_k;
    logic signed [pc_pkg::RHO_W-1:0] r_res_rho, n_res_rho;
    logic                       r_res_undef, n_res_undef;
    logic                       r_out_vld, n_out_vld;
    logic signed [pc_pkg::RHO_W-1:0] r_out_rho, n_out_rho;
    logic                       r_out_undef, n_out_undef;

    logic [pc_pkg::W-1:0]     w_add_a;
    logic [pc_pkg::W-1:0]     w_add_b;
    logic                     w_add_sub;
    logic [pc_pkg::W:0]       w_add_full;
    logic [pc_pkg::W-1:0]     w_add_s;
    logic                     w_add_co;

    logic [pc_pkg::SUM_W-1:0] w_mag_sx;
    logic [pc_pkg::SUM_W-1:0] w_mag_sy;
    logic [pc_pkg::SQ_W-1:0]  w_mag_sxy;
    logic                     w_sp;
    logic                     w_sq;
    logic [pc_pkg::SPR_W-1:0] w_spread;
    logic signed [pc_pkg::RHO_W-1:0] w_fin_rho;

    assign w_take = i_in.valid && i_in.ready;

    pc_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_take),
        .i_x         (i_in.sample_x),
        .i_y         (i_in.sample_y),
        .i_last      (i_in.last_sample),
        .i_clear     (w_clear),
        .o_sums      (w_sums),
        .o_last_pend (w_last_pend)
    );

    assign i_in.ready = (r_state == S_IDLE) && !w_last_pend;

    assign w_mag_sx  = w_sums.sx[pc_pkg::SUM_W-1] ? $unsigned(-w_sums.sx)
                                                  : $unsigned(w_sums.sx);
    assign w_mag_sy  = w_sums.sy[pc_pkg::SUM_W-1] ? $unsigned(-w_sums.sy)
                                                  : $unsigned(w_sums.sy);
    assign w_mag_sxy = w_sums.sxy[pc_pkg::SQ_W-1] ? $unsigned(-w_sums.sxy)
                                                  : $unsigned(w_sums.sxy);
    assign w_sp = w_sums.sxy[pc_pkg::SQ_W-1];
    assign w_sq = w_sums.sx[pc_pkg::SUM_W-1] ^ w_sums.sy[pc_pkg::SUM_W-1];

    // shared adder / subtractor, carry out high means no borrow
    always_comb begin
        w_add_a   = '0;
        w_add_b   = '0;
        w_add_sub = 1'b0;
        unique case (r_state)
            S_MUL: begin
                w_add_a = r_acc;
                w_add_b = r_mcand;
            end
            S_POST: begin
                w_add_a   = r_tmp;
                w_add_b   = r_acc;
                w_add_sub = (r_op == OP_SXX) || (r_op == OP_SYY) ||
                            ((r_op == OP_SXY) && (w_sp == w_sq));
            end
            S_SWAP: begin
                w_add_a   = r_acc;
                w_add_b   = r_tmp;
                w_add_sub = 1'b1;
            end
            S_CHK: begin
                w_add_a   = r_n;
                w_add_b   = r_acc;
                w_add_sub = 1'b1;
            end
            S_T1: begin
                w_add_a = r_e;
                w_add_b = r_g;
            end
            S_T2: begin
                w_add_a = r_tmp;
                w_add_b = r_dk;
            end
            S_CMP: begin
                w_add_a   = r_n;
                w_add_b   = r_tmp;
                w_add_sub = 1'b1;
            end
            S_UPG: begin
                w_add_a = r_g;
                w_add_b = r_dk << 1;
            end
            default: begin
                w_add_a = '0;
            end
        endcase
    end

    assign w_add_full = {1'b0, w_add_a} + {1'b0, (w_add_sub ? ~w_add_b : w_add_b)}
                      + {{pc_pkg::W{1'b0}}, w_add_sub};
    assign w_add_s    = w_add_full[pc_pkg::W-1:0];
    assign w_add_co   = w_add_full[pc_pkg::W];

    assign w_spread  = w_add_co ? w_add_s[pc_pkg::SPR_W-1:0] : '0;
    assign w_fin_rho = f_rho(pc_pkg::RHO_W'(r_u) + pc_pkg::RHO_W'(1), r_neg);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_acc       = r_acc;
        n_mcand     = r_mcand;
        n_mplier    = r_mplier;
        n_tmp       = r_tmp;
        n_pa        = r_pa;
        n_pb        = r_pb;
        n_num       = r_num;
        n_neg       = r_neg;
        n_n         = r_n;
        n_e         = r_e;
        n_g         = r_g;
        n_dk        = r_dk;
        n_u         = r_u;
        n_k         = r_k;
        n_res_rho   = r_res_rho;
        n_res_undef = r_res_undef;
        n_out_vld   = r_out_vld && !o_out.ready;
        n_out_rho   = r_out_rho;
        n_out_undef = r_out_undef;
        w_clear     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_last_pend) begin
                    n_op    = OP_NXX;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_acc   = '0;
                n_state = S_MUL;
                unique case (r_op)
                    OP_NXX: begin
                        n_mcand  = pc_pkg::W'(w_sums.sxx);
                        n_mplier = pc_pkg::NUM_W'(w_sums.cnt);
                    end
                    OP_SXX: begin
                        n_mcand  = pc_pkg::W'(w_mag_sx);
                        n_mplier = pc_pkg::NUM_W'(w_mag_sx);
                    end
                    OP_NYY: begin
                        n_mcand  = pc_pkg::W'(w_sums.syy);
                        n_mplier = pc_pkg::NUM_W'(w_sums.cnt);
                    end
                    OP_SYY: begin
                        n_mcand  = pc_pkg::W'(w_mag_sy);
                        n_mplier = pc_pkg::NUM_W'(w_mag_sy);
                    end
                    OP_NXY: begin
                        n_mcand  = pc_pkg::W'(w_mag_sxy);
                        n_mplier = pc_pkg::NUM_W'(w_sums.cnt);
                    end
                    OP_SXY: begin
                        n_mcand  = pc_pkg::W'(w_mag_sx);
                        n_mplier = pc_pkg::NUM_W'(w_mag_sy);
                    end
                    OP_NN: begin
                        n_mcand  = pc_pkg::W'(r_num);
                        n_mplier = r_num;
                    end
                    OP_AB: begin
                        n_mcand  = pc_pkg::W'(r_pa);
                        n_mplier = pc_pkg::NUM_W'(r_pb);
                    end
                    default: begin
                        n_mplier = '0;
                    end
                endcase
            end
            S_MUL: begin
                if (r_mplier == '0) begin
                    n_state = S_POST;
                end else begin
                    if (r_mplier[0]) begin
                        n_acc = w_add_s;
                    end
                    n_mcand  = r_mcand << 1;
                    n_mplier = r_mplier >> 1;
                end
            end
            S_POST: begin
                n_state = S_LOAD;
                unique case (r_op)
                    OP_NXX: begin
                        n_tmp = r_acc;
                        n_op  = OP_SXX;
                    end
                    OP_SXX: begin
                        n_pa = w_spread;
                        n_op = OP_NYY;
                    end
                    OP_NYY: begin
                        n_tmp = r_acc;
                        n_op  = OP_SYY;
                    end
                    OP_SYY: begin
                        n_pb = w_spread;
                        n_op = OP_NXY;
                        if ((w_spread == '0) || (r_pa == '0)) begin
                            n_res_rho   = '0;
                            n_res_undef = 1'b1;
                            n_state     = S_DONE;
                        end
                    end
                    OP_NXY: begin
                        n_tmp = r_acc;
                        n_op  = OP_SXY;
                    end
                    OP_SXY: begin
                        n_op = OP_NN;
                        if ((w_sp != w_sq) || w_add_co) begin
                            n_num = w_add_s[pc_pkg::NUM_W-1:0];
                            n_neg = w_sp;
                        end else begin
                            n_state = S_SWAP;
                        end
                    end
                    OP_NN: begin
                        n_n  = r_acc << pc_pkg::NSH;
                        n_op = OP_AB;
                    end
                    OP_AB: begin
                        n_e     = r_acc;
                        n_g     = r_acc << (pc_pkg::FRAC_W + 1);
                        n_dk    = r_acc << (2 * pc_pkg::FRAC_W);
                        n_state = S_CHK;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SWAP: begin
                n_num   = w_add_s[pc_pkg::NUM_W-1:0];
                n_neg   = !w_sp;
                n_state = S_LOAD;
            end
            S_CHK: begin
                if (w_add_co) begin
                    n_u     = '0;
                    n_k     = pc_pkg::K_W'(pc_pkg::FRAC_W - 1);
                    n_state = S_T1;
                end else begin
                    n_res_rho   = '0;
                    n_res_undef = 1'b0;
                    n_state     = S_DONE;
                end
            end
            S_T1: begin
                n_tmp   = w_add_s;
                n_state = S_T2;
            end
            S_T2: begin
                n_tmp   = w_add_s;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (w_add_co) begin
                    n_e      = r_tmp;
                    n_u[r_k] = 1'b1;
                    n_state  = S_UPG;
                end else begin
                    n_g  = r_g >> 1;
                    n_dk = r_dk >> 2;
                    if (r_k == '0) begin
                        n_res_rho   = w_fin_rho;
                        n_res_undef = 1'b0;
                        n_state     = S_DONE;
                    end else begin
                        n_k     = r_k - pc_pkg::K_W'(1);
                        n_state = S_T1;
                    end
                end
            end
            S_UPG: begin
                n_g  = w_add_s >> 1;
                n_dk = r_dk >> 2;
                if (r_k == '0) begin
                    n_res_rho   = w_fin_rho;
                    n_res_undef = 1'b0;
                    n_state     = S_DONE;
                end else begin
                    n_k     = r_k - pc_pkg::K_W'(1);
                    n_state = S_T1;
                end
            end
            S_DONE: begin
                if (!r_out_vld || o_out.ready) begin
                    n_out_vld   = 1'b1;
                    n_out_rho   = r_res_rho;
                    n_out_undef = r_res_undef;
                    w_clear     = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_op      <= OP_NXX;
            r_out_vld <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_acc       <= n_acc;
            r_mcand     <= n_mcand;
            r_mplier    <= n_mplier;
            r_tmp       <= n_tmp;
            r_pa        <= n_pa;
            r_pb        <= n_pb;
            r_num       <= n_num;
            r_neg       <= n_neg;
            r_n         <= n_n;
            r_e         <= n_e;
            r_g         <= n_g;
            r_dk        <= n_dk;
            r_u         <= n_u;
            r_k         <= n_k;
            r_res_rho   <= n_res_rho;
            r_res_undef <= n_res_undef;
            r_out_vld   <= n_out_vld;
            r_out_rho   <= n_out_rho;
            r_out_undef <= n_out_undef;
        end
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.rho       = r_out_rho;
    assign o_out.undefined = r_out_undef;

    a_last_closes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.last_sample) |=> !i_in.ready)
        else $error("input request taken right after a last pair");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == S_DONE))
        else $error("result appeared outside the done step");

    a_sums_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && ($past(r_state) == S_DONE) && (r_state == S_IDLE))
        |-> (w_sums.cnt == '0))
        else $error("sums not cleared after a result");

    a_undef_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.undefined) |-> (o_out.rho == '0))
        else $error("undefined result with nonzero rho");

endmodule

>>> sv/pc_accum.sv
// ---------------------------------------------------------------------------
// pc_accum
// input stage and running sums of x, y, x*x, y*y, x*y and the pair count
// ---------------------------------------------------------------------------
module pc_accum (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_take,
    input  logic signed [pc_pkg::IN_W-1:0] i_x,
    input  logic signed [pc_pkg::IN_W-1:0] i_y,
    input  logic                           i_last,
    input  logic                           i_clear,
    output pc_pkg::t_sums                  o_sums,
    output logic                           o_last_pend
);

    logic                                   r_stg_vld;
    logic                                   r_stg_last;
    logic signed [pc_pkg::SAMPLE_BITS-1:0]  r_stg_x;
    logic signed [pc_pkg::SAMPLE_BITS-1:0]  r_stg_y;
    pc_pkg::t_sums                          r_sums;

    logic signed [2*pc_pkg::SAMPLE_BITS-1:0] w_xx;
    logic signed [2*pc_pkg::SAMPLE_BITS-1:0] w_yy;
    logic signed [2*pc_pkg::SAMPLE_BITS-1:0] w_xy;
    logic                                    w_room;

    assign w_xx   = r_stg_x * r_stg_x;
    assign w_yy   = r_stg_y * r_stg_y;
    assign w_xy   = r_stg_x * r_stg_y;
    assign w_room = r_sums.cnt < pc_pkg::CNT_W'(pc_pkg::MAX_SAMPLES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_vld  <= 1'b0;
            r_stg_last <= 1'b0;
            r_sums     <= '0;
        end else begin
            r_stg_vld <= i_take;
            if (i_take) begin
                r_stg_x    <= $signed(i_x[pc_pkg::SAMPLE_BITS-1:0]);
                r_stg_y    <= $signed(i_y[pc_pkg::SAMPLE_BITS-1:0]);
                r_stg_last <= i_last;
            end
            if (i_clear) begin
                r_sums <= '0;
            end else if (r_stg_vld && w_room) begin
                r_sums.sx  <= r_sums.sx + pc_pkg::SUM_W'(r_stg_x);
                r_sums.sy  <= r_sums.sy + pc_pkg::SUM_W'(r_stg_y);
                r_sums.sxx <= r_sums.sxx + pc_pkg::SQ_W'($unsigned(w_xx));
                r_sums.syy <= r_sums.syy + pc_pkg::SQ_W'($unsigned(w_yy));
                r_sums.sxy <= r_sums.sxy + pc_pkg::SQ_W'(w_xy);
                r_sums.cnt <= r_sums.cnt + pc_pkg::CNT_W'(1);
            end
        end
    end

    assign o_sums      = r_sums;
    assign o_last_pend = r_stg_vld && r_stg_last;

endmodule

>>> bench/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// self-checking bench for the pearson correlation block: sample pairs go in
// column by column, each column end is predicted exactly in wide integer
// arithmetic and compared with the rho / undefined result that comes out;
// both channels idle at random, with one long output hold-off
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 1500;
    localparam int SETTLE       = 400;
    localparam int RANDOM_PAIRS = 1050;

    typedef struct packed {
        logic signed [pc_pkg::RHO_W-1:0] rho;
        logic                            undefined;
    } t_corr;

    typedef enum int {
        KIND_RANDOM,
        KIND_LINEAR,
        KIND_CONST_X,
        KIND_CONST_Y,
        KIND_EXTREME
    } t_col_kind;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pc_in_if  in_if ();
    pc_out_if out_if ();

    pearson_correlation i_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    always #1 clk = ~clk;

    pc_pkg::t_sums col_sums = '0;
    t_corr pending_rho[$];
    int    mismatches = 0;
    int    quiet_cycles = 0;
    int    pairs_sent = 0;
    int    hold_requests = 0;
    bit    tx_gaps_on = 1'b1;
    bit    rx_gaps_on = 1'b1;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic logic signed [pc_pkg::SQ_W-1:0] sample_value(
        input logic [pc_pkg::IN_W-1:0] raw);
        logic signed [pc_pkg::SAMPLE_BITS-1:0] v;
        v = raw[pc_pkg::SAMPLE_BITS-1:0];
        return v;
    endfunction

    // exact coefficient: largest q with (2q-1)^2 * den^2 <= 2^32 * num^2
    function automatic t_corr pearson_q15(input pc_pkg::t_sums s);
        logic signed [127:0] n, sx, sy, sxx, syy, sxy, spx, spy, num;
        logic [191:0] ua, ub, mag, rhs, ab, lhs;
        int unsigned lo, hi, mid;
        logic [63:0] odd;
        t_corr r;
        n   = s.cnt;
        sx  = s.sx;
        sy  = s.sy;
        sxx = s.sxx;
        syy = s.syy;
        sxy = s.sxy;
        spx = n * sxx - sx * sx;
        spy = n * syy - sy * sy;
        if (spx <= 0 || spy <= 0) begin
            r.rho = '0;
            r.undefined = 1'b1;
            return r;
        end
        num = n * sxy - sx * sy;
        mag = (num < 0) ? -num : num;
        rhs = (mag * mag) << 32;
        ua  = spx;
        ub  = spy;
        ab  = ua * ub;
        lo  = 0;
        hi  = 32768;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            odd = 2 * mid - 1;
            lhs = ab * (odd * odd);
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
        end
        if (num < 0) r.rho = pc_pkg::RHO_W'(0 - lo);
        else r.rho = (lo > 32767) ? pc_pkg::RHO_MAX : pc_pkg::RHO_W'(lo);
        r.undefined = 1'b0;
        return r;
    endfunction

    function automatic logic signed [pc_pkg::IN_W-1:0] rand_sample();
        case ($urandom_range(0, 3))
            0: return pc_pkg::IN_W'($urandom());
            1: begin
                case ($urandom_range(0, 3))
                    0: return 16'sh8000;
                    1: return 16'sh7fff;
                    2: return -16'sd1;
                    default: return '0;
                endcase
            end
            2: return pc_pkg::IN_W'(int'($urandom_range(0, 16)) - 8);
            default: return pc_pkg::IN_W'(int'($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    // accepted pairs feed the prediction, accepted results are checked
    always @(posedge clk) begin : pair_monitor
        logic signed [pc_pkg::SQ_W-1:0] xs, ys;
        t_corr want;
        if (rst_n) begin
            if (in_if.valid && in_if.ready) begin
                if (col_sums.cnt < pc_pkg::MAX_SAMPLES) begin
                    xs = sample_value(in_if.sample_x);
                    ys = sample_value(in_if.sample_y);
                    col_sums.sx  = col_sums.sx + xs;
                    col_sums.sy  = col_sums.sy + ys;
                    col_sums.sxx = col_sums.sxx + xs * xs;
                    col_sums.syy = col_sums.syy + ys * ys;
                    col_sums.sxy = col_sums.sxy + xs * ys;
                    col_sums.cnt = col_sums.cnt + 1'b1;
                end
                if (in_if.last_sample) begin
                    pending_rho.push_back(pearson_q15(col_sums));
                    col_sums = '0;
                end
            end
            if (out_if.valid && out_if.ready) begin
                if (pending_rho.size() == 0) begin
                    $display("%0t unexpected result: rho %0d undefined %0b",
                             $time, out_if.rho, out_if.undefined);
                    mismatches++;
                end else begin
                    want = pending_rho.pop_front();
                    if (out_if.rho !== want.rho) begin
                        $display("%0t rho mismatch: expected %0d, got %0d",
                                 $time, want.rho, out_if.rho);
                        mismatches++;
                    end
                    if (out_if.undefined !== want.undefined) begin
                        $display("%0t undefined mismatch: expected %0b, got %0b",
                                 $time, want.undefined, out_if.undefined);
                        mismatches++;
                    end
                end
            end
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("%0t no request accepted for %0d cycles", $time, quiet_cycles);
                    $display("== FAIL ==");
                    $finish;
                end
            end
        end
    end

    // result side ready: random stalls, plus long hold-offs on request
    initial begin : result_sink
        int stall_left;
        int hold_left;
        int holds_done;
        stall_left = 0;
        hold_left  = 0;
        holds_done = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (holds_done != hold_requests) begin
                hold_left  = HOLD_CYCLES;
                holds_done = hold_requests;
            end
            if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                out_if.ready <= 1'b1;
                if ($urandom_range(0, 199) == 0) rx_gaps_on = !rx_gaps_on;
                if (rx_gaps_on) stall_left = idle_len();
            end
        end
    end

    task automatic send_pair(input logic signed [pc_pkg::IN_W-1:0] x,
                             input logic signed [pc_pkg::IN_W-1:0] y, input logic last);
        int gap;
        gap = tx_gaps_on ? idle_len() : 0;
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid       <= 1'b1;
        in_if.sample_x    <= x;
        in_if.sample_y    <= y;
        in_if.last_sample <= last;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        pairs_sent++;
    endtask

    task automatic send_column(input int len, input t_col_kind kind);
        int sgn, noise_span, yi;
        logic signed [pc_pkg::IN_W-1:0] x, y, fixed_x, fixed_y;
        sgn        = $urandom_range(0, 1) ? 1 : -1;
        noise_span = ($urandom_range(0, 2) == 0) ? 0 : (1 << $urandom_range(0, 12));
        fixed_x    = rand_sample();
        fixed_y    = rand_sample();
        for (int i = 0; i < len; i++) begin
            x = rand_sample();
            y = rand_sample();
            case (kind)
                KIND_LINEAR: begin
                    yi = sgn * int'(x) + int'($urandom_range(0, 2 * noise_span)) - noise_span;
                    if (yi > 32767) yi = 32767;
                    if (yi < -32768) yi = -32768;
                    y = pc_pkg::IN_W'(yi);
                end
                KIND_CONST_X: x = fixed_x;
                KIND_CONST_Y: y = fixed_y;
                KIND_EXTREME: begin
                    x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                    y = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                end
                default: ;
            endcase
            send_pair(x, y, i == len - 1);
        end
    endtask

    task automatic wait_for_results();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_rho.size() != 0) @(posedge clk);
    endtask

    task automatic test_corner_columns();
        tx_gaps_on = 1'b1;
        send_pair(16'sh7fff, 16'sh8000, 1'b1);
        send_pair(16'sh8000, 16'sh8000, 1'b0);
        send_pair(16'sh7fff, 16'sh7fff, 1'b1);
        send_pair(16'sh8000, 16'sh7fff, 1'b0);
        send_pair(16'sh7fff, 16'sh8000, 1'b1);
        send_pair(16'sd5, -16'sd1, 1'b0);
        send_pair(16'sd5, 16'sd300, 1'b0);
        send_pair(16'sd5, 16'sh8000, 1'b1);
        send_pair(-16'sd7, 16'sd9, 1'b0);
        send_pair(16'sd1000, 16'sd9, 1'b0);
        send_pair(16'sh7fff, 16'sd9, 1'b1);
        send_pair(16'sd1, 16'sd1, 1'b0);
        send_pair(-16'sd1, 16'sd1, 1'b0);
        send_pair(16'sd1, -16'sd1, 1'b0);
        send_pair(-16'sd1, -16'sd1, 1'b1);
        send_pair(16'sh7fff, -16'sd1, 1'b0);
        send_pair(16'sh8000, 16'sd0, 1'b0);
        send_pair(16'sd0, 16'sh8000, 1'b0);
        send_pair(-16'sd1, 16'sh7fff, 1'b1);
    endtask

    task automatic test_backpressure();
        tx_gaps_on = 1'b0;
        hold_requests++;
        for (int c = 0; c < 6; c++) send_column(3, t_col_kind'($urandom_range(0, 4)));
        wait_for_results();
    endtask

    task automatic test_random_columns();
        int r, len, start;
        t_col_kind kind;
        start = pairs_sent;
        while (pairs_sent - start < RANDOM_PAIRS) begin
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 99);
            if (r < 10) len = 1;
            else if (r < 80) len = $urandom_range(2, 12);
            else if (r < 95) len = $urandom_range(13, 64);
            else len = $urandom_range(65, 300);
            r = $urandom_range(0, 99);
            if (r < 40) kind = KIND_RANDOM;
            else if (r < 80) kind = KIND_LINEAR;
            else if (r < 87) kind = KIND_CONST_X;
            else if (r < 94) kind = KIND_CONST_Y;
            else kind = KIND_EXTREME;
            send_column(len, kind);
            if ($urandom_range(0, 19) == 0) wait_for_results();
        end
    endtask

    initial begin
        in_if.valid       <= 1'b0;
        in_if.sample_x    <= '0;
        in_if.sample_y    <= '0;
        in_if.last_sample <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_corner_columns();
        wait_for_results();
        test_backpressure();
        test_random_columns();
        wait_for_results();
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && pending_rho.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
